// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is applied
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, switched off while reset is applied
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/drlp_pkg.sv -----
// shared types and constants of the date record line parser
package drlp_pkg;

    localparam int CAPACITY_DEF = 128;

    localparam int YEAR_W  = 14;
    localparam int CFG_IDX_W = 1;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1900;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2100;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 1'b1;

    // output queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_NO_COMMA = 4'd1,
        ST_NO_NAME  = 4'd2,
        ST_LENGTH   = 4'd3,
        ST_DASH1    = 4'd4,
        ST_DASH2    = 4'd5,
        ST_YEAR     = 4'd6,
        ST_MONTH    = 4'd7,
        ST_DAY      = 4'd8,
        ST_FULL     = 4'd9
    } t_status;

    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic               kind;
        t_status            status;
        logic signed [18:0] year;
        logic signed [12:0] month;
        logic signed [12:0] day;
        logic [7:0]         label_length;
        logic [7:0]         slot;
        logic               end_of_run;
    } t_result;

    // results handed to the output queue, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ----- rtl/core/drlp_if.sv -----
// channel interfaces: text bytes in, results out, register writes

interface drlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input text_byte, input first_byte, input last_byte,
                    output ready);
endinterface

interface drlp_out_if;
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [3:0]             status;
    logic signed [18:0]     year;
    logic signed [12:0]     month;
    logic signed [12:0]     day;
    logic [7:0]             label_length;
    logic [7:0]             slot;
    logic                   end_of_run;

    modport source (output valid, output kind, output status, output year, output month,
                    output day, output label_length, output slot, output end_of_run,
                    input ready);
    modport sink   (input valid, input kind, input status, input year, input month,
                    input day, input label_length, input slot, input end_of_run,
                    output ready);
endinterface

interface drlp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [drlp_pkg::CFG_IDX_W-1:0] index;
    logic [drlp_pkg::YEAR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/drlp_outq.sv -----
// four-entry result queue, takes up to two results per cycle
module drlp_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  drlp_pkg::t_push     i_push,
    output logic                o_room,
    drlp_out_if.source          o_out
);
    import drlp_pkg::*;

    t_result                 r_entry [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [OUTQ_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [OUTQ_CNT_W-1:0]   r_count, n_count;
    logic                    pop;
    logic [OUTQ_PTR_W-1:0]   wr_ptr_next;

    // room for two results whatever the sink does this cycle
    assign o_room      = (r_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign pop         = o_out.valid && o_out.ready;
    assign wr_ptr_next = r_wr_ptr + OUTQ_PTR_W'(1);

    always_comb begin
        n_rd_ptr = r_rd_ptr + OUTQ_PTR_W'(pop);
        n_wr_ptr = r_wr_ptr + OUTQ_PTR_W'(i_push.count);
        n_count  = r_count + OUTQ_CNT_W'(i_push.count) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_entry[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_entry[wr_ptr_next] <= i_push.second;
        end
    end

    assign o_out.valid        = (r_count != '0);
    assign o_out.kind         = r_entry[r_rd_ptr].kind;
    assign o_out.status       = r_entry[r_rd_ptr].status;
    assign o_out.year         = r_entry[r_rd_ptr].year;
    assign o_out.month        = r_entry[r_rd_ptr].month;
    assign o_out.day          = r_entry[r_rd_ptr].day;
    assign o_out.label_length = r_entry[r_rd_ptr].label_length;
    assign o_out.slot         = r_entry[r_rd_ptr].slot;
    assign o_out.end_of_run   = r_entry[r_rd_ptr].end_of_run;

endmodule

// ----- rtl/core/date_record_line_parser.sv -----
// top level: date record line parser, one text byte per transaction
// a byte's results enter the four-entry output queue registers when it is accepted
// throughput: one byte per cycle while the queue has room for two; a byte that closes
//   a line and ends the text gives two results, which leave the queue one at a time
// input ready follows only the registered queue fill, never the output ready
// reset: synchronous, active low; clears line state, counts, queue; resets year window
module date_record_line_parser #(
    parameter int CAPACITY = drlp_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drlp_in_if.sink     i_in,
    drlp_cfg_if.sink    i_cfg,
    drlp_out_if.source  o_out
);
    import drlp_pkg::*;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    // state of the open line
    typedef struct packed {
        logic               comma_seen;
        logic [7:0]         name_count;
        logic [3:0]         date_count;
        logic signed [18:0] year_acc;
        logic signed [12:0] month_acc;
        logic signed [12:0] day_acc;
        logic [1:0]         dash_flags;
        logic               cr_pending;
    } t_line;

    localparam t_line LINE_CLR = '0;

    // one character into the open line: name before the comma, then the date
    function automatic t_line add_char(input t_line s, input logic [7:0] c);
        t_line              r;
        logic signed [18:0] d_y;
        logic signed [12:0] d_md;
        r    = s;
        d_y  = $signed({11'd0, c}) - 19'sd48;
        d_md = $signed({5'd0, c}) - 13'sd48;
        if (!s.comma_seen) begin
            if (c == CH_COMMA) begin
                r.comma_seen = 1'b1;
            end else if (s.name_count != 8'd255) begin
                r.name_count = s.name_count + 8'd1;
            end
        end else begin
            if (s.date_count < 4'd4) begin
                r.year_acc = s.year_acc * 19'sd10 + d_y;
            end else if (s.date_count == 4'd4 && c == CH_DASH) begin
                r.dash_flags[0] = 1'b1;
            end else if (s.date_count == 4'd5 || s.date_count == 4'd6) begin
                r.month_acc = s.month_acc * 13'sd10 + d_md;
            end else if (s.date_count == 4'd7 && c == CH_DASH) begin
                r.dash_flags[1] = 1'b1;
            end else if (s.date_count == 4'd8 || s.date_count == 4'd9) begin
                r.day_acc = s.day_acc * 13'sd10 + d_md;
            end
            if (s.date_count < 4'd11) begin
                r.date_count = s.date_count + 4'd1;
            end
        end
        return r;
    endfunction

    // days per month, february always allowing 29
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd2:                       d = 5'd29;
            4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
            default:                    d = 5'd31;
        endcase
        return d;
    endfunction

    // configuration registers
    logic [YEAR_W-1:0] r_min_year;
    logic [YEAR_W-1:0] r_max_year;

    // text state
    t_line      r_line, n_line;
    logic [7:0] r_record_count, n_record_count;
    t_status    r_stopped, n_stopped;

    // per-byte working values
    logic       accept;
    t_line      s_base, s_a, s_mid;
    logic [7:0] rc_base;
    t_status    stop_base;
    logic       crlf;
    logic       do_close;
    logic       line_empty;
    logic       running;
    logic       line_out;
    t_status    line_status;
    logic [4:0] dim;
    t_result    line_res, sum_res;
    t_push      push;
    logic       room;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = room;
    assign accept      = i_in.valid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RST;
            r_max_year <= MAX_YEAR_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MIN_YEAR: r_min_year <= i_cfg.data;
                CFG_MAX_YEAR: r_max_year <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // a pending cr becomes a line end on lf, otherwise an ordinary character
    always_comb begin
        s_base    = i_in.first_byte ? LINE_CLR : r_line;
        rc_base   = i_in.first_byte ? 8'd0 : r_record_count;
        stop_base = i_in.first_byte ? ST_OK : r_stopped;
        running   = (stop_base == ST_OK);

        crlf = s_base.cr_pending && (i_in.text_byte == CH_LF);

        s_a            = s_base;
        s_a.cr_pending = 1'b0;
        if (s_base.cr_pending && !crlf) begin
            s_a = add_char(s_a, CH_CR);
        end

        s_mid = s_a;
        if (!crlf) begin
            if (i_in.text_byte == CH_CR && !i_in.last_byte) begin
                s_mid.cr_pending = 1'b1;
            end else begin
                s_mid = add_char(s_a, i_in.text_byte);
            end
        end

        // a line closes on cr lf or on the last byte; both at once close it only once
        do_close   = crlf || i_in.last_byte;
        line_empty = !s_mid.comma_seen && (s_mid.name_count == 8'd0);
        line_out   = running && do_close && !line_empty;
    end

    // line checks, first failing one wins
    always_comb begin
        dim = month_days(s_mid.month_acc[3:0]);
        if (!s_mid.comma_seen) begin
            line_status = ST_NO_COMMA;
        end else if (s_mid.name_count == 8'd0) begin
            line_status = ST_NO_NAME;
        end else if (s_mid.date_count != 4'd10) begin
            line_status = ST_LENGTH;
        end else if (!s_mid.dash_flags[0]) begin
            line_status = ST_DASH1;
        end else if (!s_mid.dash_flags[1]) begin
            line_status = ST_DASH2;
        end else if (s_mid.year_acc < $signed({5'd0, r_min_year})
                  || s_mid.year_acc > $signed({5'd0, r_max_year})) begin
            line_status = ST_YEAR;
        end else if (s_mid.month_acc < 13'sd1 || s_mid.month_acc > 13'sd12) begin
            line_status = ST_MONTH;
        end else if (s_mid.day_acc < 13'sd1 || s_mid.day_acc > $signed({8'd0, dim})) begin
            line_status = ST_DAY;
        end else if (rc_base >= 8'(CAPACITY)) begin
            line_status = ST_FULL;
        end else begin
            line_status = ST_OK;
        end
    end

    // next text state; a stopped text keeps everything until a first byte
    always_comb begin
        n_line         = s_base;
        n_record_count = rc_base;
        n_stopped      = stop_base;
        if (running) begin
            n_line = do_close ? LINE_CLR : s_mid;
            if (line_out) begin
                if (line_status == ST_OK) begin
                    n_record_count = rc_base + 8'd1;
                end else begin
                    n_stopped = line_status;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line         <= LINE_CLR;
            r_record_count <= 8'd0;
            r_stopped      <= ST_OK;
        end else if (accept) begin
            r_line         <= n_line;
            r_record_count <= n_record_count;
            r_stopped      <= n_stopped;
        end
    end

    // result assembly: line result first, summary after it
    always_comb begin
        line_res.kind         = KIND_LINE;
        line_res.status       = line_status;
        line_res.year         = s_mid.year_acc;
        line_res.month        = s_mid.month_acc;
        line_res.day          = s_mid.day_acc;
        line_res.label_length = s_mid.name_count;
        line_res.slot         = (line_status == ST_OK) ? rc_base : 8'd0;
        line_res.end_of_run   = !i_in.last_byte;

        sum_res.kind          = KIND_SUMMARY;
        sum_res.status        = n_stopped;
        sum_res.year          = '0;
        sum_res.month         = '0;
        sum_res.day           = '0;
        sum_res.label_length  = 8'd0;
        sum_res.slot          = n_record_count;
        sum_res.end_of_run    = 1'b1;

        push.first  = line_out ? line_res : sum_res;
        push.second = sum_res;
        if (!accept) begin
            push.count = 2'd0;
        end else begin
            push.count = 2'(line_out) + 2'(i_in.last_byte);
        end
    end

    drlp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/core/drlp_checker.sv -----
// port-level checks on the parser output, bound to the top level
`include "assert_macros.svh"

module drlp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_out_kind,
    input  logic [3:0]         i_out_status,
    input  logic signed [18:0] i_out_year,
    input  logic [7:0]         i_out_label_length,
    input  logic [7:0]         i_out_slot,
    input  logic               i_out_end_of_run
);
    import drlp_pkg::*;

    // queue is empty straight after reset
    `ASSERT_NEXT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n, !i_out_valid)

    // a summary is always the last result of its byte
    `ASSERT_IMPLY(a_summary_ends_run, i_clk, i_rst_n,
        i_out_valid && i_out_kind == KIND_SUMMARY, i_out_end_of_run)

    // a failed line takes no slot
    `ASSERT_IMPLY(a_failed_line_no_slot, i_clk, i_rst_n,
        i_out_valid && i_out_kind == KIND_LINE && i_out_status != ST_OK, i_out_slot == 8'd0)

    // a stalled result holds
    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_slot) && $stable(i_out_year)
        && $stable(i_out_status) && $stable(i_out_label_length))

endmodule

bind date_record_line_parser drlp_checker u_drlp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_kind         (o_out.kind),
    .i_out_status       (o_out.status),
    .i_out_year         (o_out.year),
    .i_out_label_length (o_out.label_length),
    .i_out_slot         (o_out.slot),
    .i_out_end_of_run   (o_out.end_of_run)
);

// ----- tb/tb_top.sv -----
// self-checking testbench of the date record line parser: directed texts, then random texts
`timescale 1ns / 100ps

module tb_top;
    import drlp_pkg::*;

    // character codes the parser reacts to
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam int MONTH_DAYS [12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // clocks waited once no result is owed any more
    localparam int DRAIN_CYCLES = 4;
    // long receiver hold-off, long enough for the output queue to fill and the input to stall behind it
    localparam int LONG_HOLD    = 600;
    // least number of random bytes per year-window phase
    localparam int PHASE_BYTES  = 100;
    localparam int NUM_PHASES   = 6;

    // one row of the directed part: optional run of a fill byte, then the text
    typedef struct {
        int    fill_byte;
        int    fill_count;
        string txt;
        bit    first;
        bit    last;
        int    status;      // typed line status, -1 leaves it to the predictor
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    drlp_in_if  in_if ();
    drlp_out_if out_if ();
    drlp_cfg_if cfg_if ();

    date_record_line_parser u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #6 i_clk = ~i_clk;

    // predictor copy of the parser state and year window
    int       rec_count;
    t_status  halt_code;
    bit       comma_found;
    int       name_len;
    int       date_len;
    int       year_sum;
    int       month_sum;
    int       day_sum;
    bit [1:0] dash_seen;
    bit       cr_held;
    int       win_lo;
    int       win_hi;

    // results still owed by the block, oldest first
    t_result     pending_results[$];
    int          mismatch_count = 0;

    logic [7:0]  text_buf[$];
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int          random_sent;

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    function automatic void reset_line_state();
        comma_found = 1'b0;
        name_len    = 0;
        date_len    = 0;
        year_sum    = 0;
        month_sum   = 0;
        day_sum     = 0;
        dash_seen   = 2'b00;
        cr_held     = 1'b0;
    endfunction

    // one character of the open line: name up to the first comma, then the date
    function automatic void take_char(input logic [7:0] c);
        int d;
        d = int'(c) - 48;
        if (!comma_found) begin
            if (c == CH_COMMA)
                comma_found = 1'b1;
            else if (name_len < 255)
                name_len++;
            return;
        end
        if (date_len < 4)
            year_sum = year_sum * 10 + d;
        else if (date_len == 4 && c == CH_DASH)
            dash_seen[0] = 1'b1;
        else if (date_len == 5 || date_len == 6)
            month_sum = month_sum * 10 + d;
        else if (date_len == 7 && c == CH_DASH)
            dash_seen[1] = 1'b1;
        else if (date_len == 8 || date_len == 9)
            day_sum = day_sum * 10 + d;
        if (date_len < 11)
            date_len++;
    endfunction

    // closes the open line; an empty line gives nothing
    task automatic close_record_line(output t_result r, output bit got);
        t_status st;
        st  = ST_OK;
        r   = '0;
        got = 1'b0;
        if (!comma_found && name_len == 0) begin
            reset_line_state();
            return;
        end
        // checks in order of the status codes, first failure wins
        if (!comma_found)
            st = ST_NO_COMMA;
        else if (name_len == 0)
            st = ST_NO_NAME;
        else if (date_len != 10)
            st = ST_LENGTH;
        else if (!dash_seen[0])
            st = ST_DASH1;
        else if (!dash_seen[1])
            st = ST_DASH2;
        else if (year_sum < win_lo || year_sum > win_hi)
            st = ST_YEAR;
        else if (month_sum < 1 || month_sum > 12)
            st = ST_MONTH;
        else if (day_sum < 1 || day_sum > MONTH_DAYS[month_sum-1])
            st = ST_DAY;
        else if (rec_count >= CAPACITY_DEF)
            st = ST_FULL;
        r.kind         = KIND_LINE;
        r.status       = st;
        r.year         = year_sum[18:0];
        r.month        = month_sum[12:0];
        r.day          = day_sum[12:0];
        r.label_length = name_len[7:0];
        if (st == ST_OK) begin
            r.slot = rec_count[7:0];
            rec_count++;
        end else begin
            halt_code = st;
        end
        reset_line_state();
        got = 1'b1;
    endtask

    // all results that one accepted byte causes, in order
    task automatic parse_text_byte(input logic [7:0] c, input bit first, input bit last,
                                   output t_result res[2], output int n);
        t_result one;
        bit      got;
        bit      taken;
        n     = 0;
        taken = 1'b0;
        res[0] = '0;
        res[1] = '0;
        if (first) begin
            rec_count = 0;
            halt_code = ST_OK;
            reset_line_state();
        end
        if (halt_code == ST_OK) begin
            // a held CR either pairs with LF into a line break or becomes text
            if (cr_held) begin
                cr_held = 1'b0;
                if (c == CH_LF) begin
                    close_record_line(one, got);
                    if (got) begin
                        res[n] = one;
                        n++;
                    end
                    taken = 1'b1;
                end else begin
                    take_char(CH_CR);
                end
            end
            if (!taken) begin
                if (c == CH_CR && !last)
                    cr_held = 1'b1;
                else
                    take_char(c);
            end
            if (last && halt_code == ST_OK) begin
                close_record_line(one, got);
                if (got) begin
                    res[n] = one;
                    n++;
                end
            end
        end
        if (last) begin
            one        = '0;
            one.kind   = KIND_SUMMARY;
            one.status = halt_code;
            one.slot   = rec_count[7:0];
            res[n]     = one;
            n++;
        end
        if (n > 0)
            res[n-1].end_of_run = 1'b1;
    endtask

    // ---------------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------------

    // offers one byte after a random gap and records what it must produce
    task automatic send_byte(input logic [7:0] b, input bit first, input bit last,
                             input int typed_status);
        t_result res[2];
        int      n;
        int      gap;
        gap = tx_calm ? 0 : $urandom_range(11, 0);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.text_byte  <= b;
        in_if.first_byte <= first;
        in_if.last_byte  <= last;
        do @(posedge i_clk); while (!in_if.ready);
        parse_text_byte(b, first, last, res, n);
        for (int i = 0; i < n; i++) begin
            if (typed_status >= 0 && res[i].kind == KIND_LINE)
                res[i].status = t_status'(typed_status);
            pending_results.push_back(res[i]);
        end
    endtask

    task automatic write_year_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value[YEAR_W-1:0];
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_MIN_YEAR)
            win_lo = value;
        else
            win_hi = value;
    endtask

    // the block is idle once every owed result is in and its pipeline has emptied
    task automatic wait_results_drained();
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic append_number(input int value, input int digits);
        for (int i = digits - 1; i >= 0; i--)
            text_buf.push_back(CH_ZERO + 8'((value / (10 ** i)) % 10));
    endtask

    // well-formed record with a random name and a valid date, inside the window when that is not empty
    task automatic append_record_line();
        int         nlen;
        int         yr;
        int         mo;
        int         dy;
        logic [7:0] c;
        nlen = $urandom_range(8, 1);
        for (int i = 0; i < nlen; i++) begin
            // no comma and no CR here, so the line cannot split by chance
            do c = 8'($urandom_range(255, 0)); while (c == CH_COMMA || c == CH_CR);
            text_buf.push_back(c);
        end
        // a lone CR in the name is ordinary text
        if ($urandom_range(9, 0) == 0) begin
            text_buf.push_back(CH_CR);
            text_buf.push_back("c");
        end
        text_buf.push_back(CH_COMMA);
        if (win_lo <= win_hi)
            yr = $urandom_range(win_hi, win_lo);
        else
            yr = $urandom_range(9999, 0);
        mo = $urandom_range(12, 1);
        dy = $urandom_range(MONTH_DAYS[mo-1], 1);
        append_number(yr, 4);
        text_buf.push_back(CH_DASH);
        append_number(mo, 2);
        text_buf.push_back(CH_DASH);
        append_number(dy, 2);
    endtask

    // a text of a few lines: mostly good records, some empty, broken or noise lines
    task automatic send_random_text();
        int  nlines;
        int  pick;
        int  start;
        int  idx;
        bit  use_first;
        bit  first;
        bit  last;
        text_buf.delete();
        nlines = $urandom_range(6, 1);
        for (int l = 0; l < nlines; l++) begin
            pick = $urandom_range(99, 0);
            if (pick < 8) begin
                // empty line
            end else if (pick < 13) begin
                repeat ($urandom_range(15, 1)) text_buf.push_back(8'($urandom_range(255, 0)));
            end else begin
                start = text_buf.size();
                append_record_line();
                if (pick >= 85) begin
                    // broken record: one character replaced or dropped
                    idx = $urandom_range(text_buf.size() - 1, start);
                    if ($urandom_range(1, 0))
                        text_buf[idx] = 8'($urandom_range(255, 0));
                    else
                        text_buf.delete(idx);
                end
            end
            if (l < nlines - 1 || $urandom_range(1, 0)) begin
                text_buf.push_back(CH_CR);
                text_buf.push_back(CH_LF);
            end
        end
        if (text_buf.size() == 0) begin
            text_buf.push_back(CH_CR);
            text_buf.push_back(CH_LF);
        end
        tx_calm   = ($urandom_range(3, 0) == 0);
        use_first = ($urandom_range(9, 0) != 0);
        foreach (text_buf[i]) begin
            // stray start or end flags in mid text now and then
            first = (i == 0 && use_first) || ($urandom_range(99, 0) == 0);
            last  = (i == text_buf.size() - 1) || ($urandom_range(149, 0) == 0);
            send_byte(text_buf[i], first, last, -1);
        end
        random_sent += text_buf.size();
    endtask

    // ---------------------------------------------------------------------
    // result side: random stalls, two long hold-offs to fill the block
    // ---------------------------------------------------------------------

    initial begin : result_sink
        int stall_left;
        int taken;
        stall_left = 0;
        taken      = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (out_if.valid && out_if.ready) begin
                    taken++;
                    if (taken % 48 == 0)
                        rx_calm = ($urandom_range(2, 0) == 0);
                    // long hold-offs while the sender keeps offering bytes
                    if (taken == 8 || taken == 60)
                        stall_left = LONG_HOLD;
                    else
                        stall_left = rx_calm ? 0 : $urandom_range(11, 0);
                end else if (stall_left > 0) begin
                    stall_left--;
                end
                out_if.ready <= (stall_left == 0);
            end
        end
    end

    // every result transaction is matched against the oldest owed result
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected: kind %0d status %0d",
                       out_if.kind, out_if.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_if.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
                    mismatch_count++;
                end
                if (out_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_if.status);
                    mismatch_count++;
                end
                if (out_if.year !== want.year) begin
                    $error("year: expected %0d, got %0d", want.year, out_if.year);
                    mismatch_count++;
                end
                if (out_if.month !== want.month) begin
                    $error("month: expected %0d, got %0d", want.month, out_if.month);
                    mismatch_count++;
                end
                if (out_if.day !== want.day) begin
                    $error("day: expected %0d, got %0d", want.day, out_if.day);
                    mismatch_count++;
                end
                if (out_if.label_length !== want.label_length) begin
                    $error("label_length: expected %0d, got %0d",
                           want.label_length, out_if.label_length);
                    mismatch_count++;
                end
                if (out_if.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, out_if.slot);
                    mismatch_count++;
                end
                if (out_if.end_of_run !== want.end_of_run) begin
                    $error("end_of_run: expected %0d, got %0d",
                           want.end_of_run, out_if.end_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------

    // directed texts: reset window, each line error code but ST_FULL, CR handling, extreme bytes
    t_row text_plan [21] = '{
        // text of one empty line: summary only, nothing counted after reset
        '{0,   0,   "\015\012",                     1'b1, 1'b0 | 1'b1, -1},
        // leap day 2000-02-29 accepted, then both window edges
        '{0,   0,   "ab,2000-02-29\015\012",        1'b1, 1'b0, ST_OK},
        '{0,   0,   "cd,1900-01-31\015\012",        1'b0, 1'b0, ST_OK},
        '{0,   0,   "e,2100-12-31",                 1'b0, 1'b1, ST_OK},
        // empty lines ignored, then a line with no comma
        '{0,   0,   "\015\012\015\012nocomma\015\012", 1'b1, 1'b0, ST_NO_COMMA},
        '{0,   0,   ",2000-01-01",                  1'b1, 1'b1, ST_NO_NAME},
        '{0,   0,   "n,2000-01-0\015\012",          1'b1, 1'b0, ST_LENGTH},
        '{0,   0,   "n,2000-01-011\015\012",        1'b1, 1'b0, ST_LENGTH},
        '{0,   0,   "n,2000x01-01\015\012",         1'b1, 1'b0, ST_DASH1},
        '{0,   0,   "n,2000-01x01\015\012",         1'b1, 1'b0, ST_DASH2},
        '{0,   0,   "n,1899-12-31\015\012",         1'b1, 1'b0, ST_YEAR},
        '{0,   0,   "n,2101-01-01\015\012",         1'b1, 1'b0, ST_YEAR},
        '{0,   0,   "n,2000-00-10\015\012",         1'b1, 1'b0, ST_MONTH},
        '{0,   0,   "n,2000-13-10\015\012",         1'b1, 1'b0, ST_MONTH},
        '{0,   0,   "n,2000-04-31\015\012",         1'b1, 1'b0, ST_DAY},
        '{0,   0,   "n,2000-01-00\015\012",         1'b1, 1'b0, ST_DAY},
        // stopped text: good line ignored, summary still carries the error
        '{0,   0,   "a,2000-01-01\015\012",         1'b0, 1'b0, -1},
        '{0,   0,   "x",                            1'b0, 1'b1, -1},
        // zero byte in the name, and a lone CR before the comma
        '{0,   1,   "\015,2000-01-01\015\012",      1'b1, 1'b0, ST_OK},
        // name saturating at 255 and ending in byte 255
        '{"n", 300, "\377,2000-06-30",              1'b0, 1'b1, ST_OK},
        // text goes on without a start flag; CR as last byte is part of the date
        '{0,   0,   "q,2000-07-31\015",             1'b0, 1'b1, ST_LENGTH}
    };

    initial begin : stimulus
        int         total;
        int         phase_lo;
        int         phase_hi;
        logic [7:0] b;

        in_if.valid      <= 1'b0;
        in_if.text_byte  <= '0;
        in_if.first_byte <= 1'b0;
        in_if.last_byte  <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= CFG_MIN_YEAR;
        cfg_if.data      <= '0;

        win_lo      = int'(MIN_YEAR_RST);
        win_hi      = int'(MAX_YEAR_RST);
        rec_count   = 0;
        halt_code   = ST_OK;
        random_sent = 0;
        reset_line_state();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset window
        tx_calm = 1'b0;
        foreach (text_plan[r]) begin
            total = text_plan[r].fill_count + text_plan[r].txt.len();
            for (int k = 0; k < total; k++) begin
                if (k < text_plan[r].fill_count)
                    b = text_plan[r].fill_byte[7:0];
                else
                    b = text_plan[r].txt[k - text_plan[r].fill_count];
                send_byte(b, text_plan[r].first && k == 0,
                          text_plan[r].last && k == total - 1, text_plan[r].status);
            end
        end
        in_if.valid <= 1'b0;
        wait_results_drained();

        // random part, one year window per phase, written while the block is idle
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin phase_lo = 0;    phase_hi = 9999; end
                1: begin phase_lo = 9999; phase_hi = 0;    end
                2: begin phase_lo = 0;    phase_hi = 0;    end
                3: begin phase_lo = 9999; phase_hi = 9999; end
                4: begin phase_lo = 1000; phase_hi = 3000; end
                default: begin
                    phase_lo = $urandom_range(9999, 0);
                    phase_hi = $urandom_range(9999, 0);
                end
            endcase
            write_year_reg(CFG_MIN_YEAR, phase_lo);
            write_year_reg(CFG_MAX_YEAR, phase_hi);
            random_sent = 0;
            while (random_sent < PHASE_BYTES)
                send_random_text();
            // sender pauses here until every owed result is in
            in_if.valid <= 1'b0;
            wait_results_drained();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin : watchdog
        #10ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/drlp_pkg.sv
rtl/core/drlp_if.sv
rtl/core/drlp_outq.sv
rtl/core/date_record_line_parser.sv
rtl/core/drlp_checker.sv
tb/tb_top.sv
